// File: rtl/hsms_pkg.sv
// Shared types and constants for the heading/speed motion sequencer.
// No dependencies; imported by every module of the block.
package hsms_pkg;

   // Motion modes, also the encoding of the rsp_mode port
   typedef enum logic [2:0] {
      MODE_STOPPED = 3'd0,
      MODE_ACCEL   = 3'd1,
      MODE_DECEL   = 3'd2,
      MODE_TURNING = 3'd3,
      MODE_CRUISE  = 3'd4
   } mode_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_TURN_THRESHOLD = 3'd0;
   localparam logic [2:0] CSR_CRUISE_SPEED   = 3'd1;
   localparam logic [2:0] CSR_SPEED_STEP     = 3'd2;
   localparam logic [2:0] CSR_MAX_TURN_STEP  = 3'd3;
   localparam logic [2:0] CSR_TURN_RATE_STEP = 3'd4;

   // Configuration reset values
   localparam logic [14:0] TURN_THRESHOLD_RST = 15'd1820;
   localparam logic [15:0] CRUISE_SPEED_RST   = 16'd5120;
   localparam logic [15:0] SPEED_STEP_RST     = 16'd256;
   localparam logic [14:0] MAX_TURN_STEP_RST  = 15'd364;
   localparam logic [14:0] TURN_RATE_STEP_RST = 15'd364;

   // 0.01 rad in angle LSB, 0.01 in Q8.8 LSB
   localparam logic [15:0] ANGLE_EPS = 16'd104;
   localparam logic [15:0] SPEED_EPS = 16'd3;

   // Restoring divider: one quotient bit per cycle
   localparam int          DIV_BITS  = 16;
   localparam logic [3:0]  DIV_LAST  = 4'(DIV_BITS - 1);

   // Datapath operations issued by the controller, one per cycle
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MAG,
      OP_ACCEL_STEP,
      OP_TO_DECEL,
      OP_DECEL_STEP,
      OP_CRUISE_STEP,
      OP_TURN_STEP,
      OP_TURN_CHECK,
      OP_REST_ALIGN,
      OP_DIV_START,
      OP_DIV_ITER,
      OP_DIV_DONE,
      OP_OUT_LOAD
   } op_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAG,
      ST_EXEC,
      ST_REST,
      ST_DIV,
      ST_DIV_END,
      ST_TURN_CHECK,
      ST_OUT
   } state_type;

   // Datapath status seen by the controller
   typedef struct packed {
      mode_type mode;
      logic     mag_gt_thr;   // error above turn threshold
      logic     mag_gt_big;   // error above twice the threshold
      logic     fast;         // speed above a tenth of cruise
      logic     decel_stop;   // next decel step ends at standstill
      logic     div_last;     // current divider iteration is the last
      logic     out_free;     // result register can take a new result
   } status_type;

endpackage

// File: rtl/hsms_dp.sv
// Datapath of the motion sequencer: config registers, motion state,
// restoring divider and result register. Depends on hsms_pkg.
module hsms_dp
   import hsms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  op_type      op,
   output status_type  status,
   input  logic [15:0] req_desired_direction,
   input  logic        csr_valid,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [2:0]  rsp_mode,
   output logic [15:0] rsp_heading,
   output logic [15:0] rsp_speed,
   output logic [15:0] rsp_turn_steps_left
);

   // config
   logic [14:0] thr_ff,    thr_in;
   logic [15:0] cruise_ff, cruise_in;
   logic [15:0] step_ff,   step_in;
   logic [14:0] maxt_ff,   maxt_in;
   logic [14:0] rate_ff,   rate_in;

   // motion state
   mode_type    mode_ff,    mode_in;
   logic [15:0] heading_ff, heading_in;
   logic [15:0] speed_ff,   speed_in;
   logic [15:0] budget_ff,  budget_in;

   // working registers
   logic [15:0] desired_ff, desired_in;
   logic [15:0] mag_ff,     mag_in;
   logic [14:0] rem_ff,     rem_in;
   logic [15:0] quot_ff,    quot_in;
   logic [3:0]  cnt_ff,     cnt_in;

   // result register
   logic        rvalid_ff,  rvalid_in;
   logic [2:0]  rmode_ff,   rmode_in;
   logic [15:0] rhead_ff,   rhead_in;
   logic [15:0] rspeed_ff,  rspeed_in;
   logic [15:0] rbudget_ff, rbudget_in;

   logic [15:0] err_w, mag_w, turned_w;
   logic [16:0] err_ext, lim_pos, lim_neg, clamp_w;
   logic [16:0] spd_sum;
   logic [15:0] spd_acc, spd_dec, budget_dec;
   logic        acc_cruise;
   logic [19:0] speed_x10;
   logic [14:0] divisor_w;
   logic [16:0] div_num;
   logic [15:0] div_shift, div_diff;
   logic        div_ge;

   // wrapped heading error and magnitude (magnitude 0..32768)
   assign err_w = desired_ff - heading_ff;
   assign mag_w = err_w[15] ? (16'd0 - err_w) : err_w;

   // limited turn toward the target
   assign err_ext = {err_w[15], err_w};
   assign lim_pos = {2'b00, maxt_ff};
   assign lim_neg = 17'd0 - lim_pos;
   always_comb begin
      if ($signed(err_ext) > $signed(lim_pos)) begin
         clamp_w = lim_pos;
      end else if ($signed(err_ext) < $signed(lim_neg)) begin
         clamp_w = lim_neg;
      end else begin
         clamp_w = err_ext;
      end
   end
   assign turned_w = heading_ff + clamp_w[15:0];

   // speed ramps
   assign spd_sum    = {1'b0, speed_ff} + {1'b0, step_ff};
   assign spd_acc    = (spd_sum < {1'b0, cruise_ff}) ? spd_sum[15:0] : cruise_ff;
   assign acc_cruise = ({1'b0, spd_acc} + {1'b0, SPEED_EPS}) >= {1'b0, cruise_ff};
   assign spd_dec    = (speed_ff > step_ff) ? (speed_ff - step_ff) : 16'd0;
   assign speed_x10  = ({4'b0, speed_ff} << 3) + ({4'b0, speed_ff} << 1);
   assign budget_dec = budget_ff - 16'd1;

   // divider: ceil(mag / rate), zero rate acts as one
   assign divisor_w = (rate_ff == 15'd0) ? 15'd1 : rate_ff;
   assign div_num   = {1'b0, mag_ff} + {2'b00, divisor_w} - 17'd1;
   assign div_shift = {rem_ff, quot_ff[15]};
   assign div_ge    = div_shift >= {1'b0, divisor_w};
   assign div_diff  = div_shift - {1'b0, divisor_w};

   always_comb begin
      status.mode       = mode_ff;
      status.mag_gt_thr = mag_ff > {1'b0, thr_ff};
      status.mag_gt_big = {1'b0, mag_ff} > {1'b0, thr_ff, 1'b0};
      status.fast       = speed_x10 > {4'b0, cruise_ff};
      status.decel_stop = spd_dec < SPEED_EPS;
      status.div_last   = cnt_ff == 4'd0;
      status.out_free   = !rvalid_ff || rsp_ready;
   end

   // config writes
   always_comb begin
      thr_in    = thr_ff;
      cruise_in = cruise_ff;
      step_in   = step_ff;
      maxt_in   = maxt_ff;
      rate_in   = rate_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TURN_THRESHOLD: thr_in    = csr_data[14:0];
            CSR_CRUISE_SPEED:   cruise_in = csr_data;
            CSR_SPEED_STEP:     step_in   = csr_data;
            CSR_MAX_TURN_STEP:  maxt_in   = csr_data[14:0];
            CSR_TURN_RATE_STEP: rate_in   = csr_data[14:0];
            default: ;
         endcase
      end
   end

   // operation decode
   always_comb begin
      mode_in    = mode_ff;
      heading_in = heading_ff;
      speed_in   = speed_ff;
      budget_in  = budget_ff;
      desired_in = desired_ff;
      mag_in     = mag_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      rvalid_in  = rvalid_ff && !rsp_ready;
      rmode_in   = rmode_ff;
      rhead_in   = rhead_ff;
      rspeed_in  = rspeed_ff;
      rbudget_in = rbudget_ff;
      unique case (op)
         OP_NONE: ;
         OP_CAPTURE: desired_in = req_desired_direction;
         OP_MAG:     mag_in = mag_w;
         OP_ACCEL_STEP: begin
            heading_in = turned_w;
            speed_in   = spd_acc;
            if (acc_cruise) begin
               mode_in = MODE_CRUISE;
            end
         end
         OP_TO_DECEL: mode_in = MODE_DECEL;
         OP_DECEL_STEP: speed_in = (spd_dec < SPEED_EPS) ? 16'd0 : spd_dec;
         OP_CRUISE_STEP: begin
            heading_in = turned_w;
            speed_in   = cruise_ff;
         end
         OP_TURN_STEP: heading_in = turned_w;
         OP_TURN_CHECK: begin
            // mag_w already reflects the heading after this step's turn
            if (budget_ff == 16'd0) begin
               mode_in = MODE_ACCEL;
            end else begin
               budget_in = budget_dec;
               if (budget_dec == 16'd0 || mag_w < ANGLE_EPS) begin
                  mode_in = MODE_ACCEL;
               end
            end
         end
         OP_REST_ALIGN: begin
            heading_in = desired_ff;
            mode_in    = MODE_ACCEL;
         end
         OP_DIV_START: begin
            rem_in  = 15'd0;
            quot_in = div_num[15:0];
            cnt_in  = DIV_LAST;
         end
         OP_DIV_ITER: begin
            rem_in  = div_ge ? div_diff[14:0] : div_shift[14:0];
            quot_in = {quot_ff[14:0], div_ge};
            cnt_in  = cnt_ff - 4'd1;
         end
         OP_DIV_DONE: begin
            budget_in = quot_ff;
            mode_in   = MODE_TURNING;
         end
         OP_OUT_LOAD: begin
            rvalid_in  = 1'b1;
            rmode_in   = mode_ff;
            rhead_in   = heading_ff;
            rspeed_in  = speed_ff;
            rbudget_in = budget_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= TURN_THRESHOLD_RST;
         cruise_ff  <= CRUISE_SPEED_RST;
         step_ff    <= SPEED_STEP_RST;
         maxt_ff    <= MAX_TURN_STEP_RST;
         rate_ff    <= TURN_RATE_STEP_RST;
         mode_ff    <= MODE_STOPPED;
         heading_ff <= 16'd0;
         speed_ff   <= 16'd0;
         budget_ff  <= 16'd0;
         cnt_ff     <= 4'd0;
         rvalid_ff  <= 1'b0;
      end else begin
         thr_ff     <= thr_in;
         cruise_ff  <= cruise_in;
         step_ff    <= step_in;
         maxt_ff    <= maxt_in;
         rate_ff    <= rate_in;
         mode_ff    <= mode_in;
         heading_ff <= heading_in;
         speed_ff   <= speed_in;
         budget_ff  <= budget_in;
         cnt_ff     <= cnt_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      desired_ff <= desired_in;
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      rmode_ff   <= rmode_in;
      rhead_ff   <= rhead_in;
      rspeed_ff  <= rspeed_in;
      rbudget_ff <= rbudget_in;
   end

   assign rsp_valid           = rvalid_ff;
   assign rsp_mode            = rmode_ff;
   assign rsp_heading         = rhead_ff;
   assign rsp_speed           = rspeed_ff;
   assign rsp_turn_steps_left = rbudget_ff;

endmodule

// File: rtl/hsms_ctrl.sv
// Controller of the motion sequencer: sequences one step per transaction
// as datapath operations. Depends on hsms_pkg.
module hsms_ctrl
   import hsms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output op_type     op
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: state_in = ST_EXEC;
         ST_EXEC: begin
            unique case (status.mode)
               MODE_ACCEL:   state_in = ST_OUT;
               MODE_CRUISE:  state_in = ST_OUT;
               MODE_DECEL:   state_in = status.decel_stop ? ST_REST : ST_OUT;
               MODE_TURNING: state_in = ST_TURN_CHECK;
               default:      state_in = ST_REST;
            endcase
         end
         ST_REST:       state_in = status.mag_gt_thr ? ST_DIV : ST_OUT;
         ST_DIV: begin
            if (status.div_last) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END:    state_in = ST_OUT;
         ST_TURN_CHECK: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op = OP_CAPTURE;
            end
         end
         ST_MAG: op = OP_MAG;
         ST_EXEC: begin
            unique case (status.mode)
               MODE_ACCEL: begin
                  op = (status.mag_gt_big && status.fast) ? OP_TO_DECEL : OP_ACCEL_STEP;
               end
               MODE_CRUISE:  op = status.mag_gt_big ? OP_TO_DECEL : OP_CRUISE_STEP;
               MODE_DECEL:   op = OP_DECEL_STEP;
               MODE_TURNING: op = OP_TURN_STEP;
               default:      op = OP_NONE;
            endcase
         end
         ST_REST:       op = status.mag_gt_thr ? OP_DIV_START : OP_REST_ALIGN;
         ST_DIV:        op = OP_DIV_ITER;
         ST_DIV_END:    op = OP_DIV_DONE;
         ST_TURN_CHECK: op = OP_TURN_CHECK;
         ST_OUT: begin
            if (status.out_free) begin
               op = OP_OUT_LOAD;
            end
         end
         default: op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/heading_speed_motion_sequencer_top.sv
// Top level of the heading/speed motion sequencer: controller plus datapath.
// Depends on hsms_pkg, hsms_ctrl and hsms_dp.
//
// Usage:
//  - req_ channel: one transaction at a time, carrying the desired
//    heading (16-bit binary angle, 32768 = pi). Each request runs one step of
//    the stopped / accel / decel / turning / cruise machine.
//  - rsp_ channel: exactly one transaction per request, in order: next mode,
//    heading, Q8.8 speed and remaining turn step budget after the step.
//  - csr_ channel: register writes (index 0..4: turn threshold, cruise speed,
//    speed step, max turn step, turn rate step). Always ready; indexes past
//    the list are dropped. Write only while no request is in flight.
//  - Sequence: capture, MAG, EXEC, then OUT loads the result; a turning step
//    adds TURN_CHECK, an aligning stop REST, and a started turn REST, the
//    restoring divider (DIV, one bit/cycle) and DIV_END before OUT.
//  - Flow control: one request at a time; req_ready returns the cycle after
//    the result is loaded.
//  - Stall: a held result sits in the output register; the next step runs up
//    to its result and then waits until rsp_ready frees that register.
//  - Reset (synchronous): registers to their defaults, mode stopped, heading,
//    speed and budget zero, no result pending.
module heading_speed_motion_sequencer_top
   import hsms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_desired_direction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_mode,
   output logic [15:0] rsp_heading,
   output logic [15:0] rsp_speed,
   output logic [15:0] rsp_turn_steps_left,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   op_type     op;
   status_type status;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   hsms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .op        (op)
   );

   hsms_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .op                    (op),
      .status                (status),
      .req_desired_direction (req_desired_direction),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_mode              (rsp_mode),
      .rsp_heading           (rsp_heading),
      .rsp_speed             (rsp_speed),
      .rsp_turn_steps_left   (rsp_turn_steps_left)
   );

`ifndef SYNTHESIS
   // one request in flight: the cycle after an accept is never ready
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a step was in progress");

   // every step leaves the machine out of the stopped mode
   a_never_stopped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode != MODE_STOPPED))
      else $error("result reports stopped mode");

   // a turn in progress always has budget left
   a_turn_budget: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mode == MODE_TURNING) |-> (rsp_turn_steps_left != 16'd0))
      else $error("turning mode with empty budget");
`endif

endmodule

// File: bench/heading_speed_motion_sequencer_top_test.sv
// Self-checking testbench for heading_speed_motion_sequencer_top: directed plan,
// then random phases. Depends on hsms_pkg and the RTL; holds its own step predictor.
`timescale 1ns / 1ps

module heading_speed_motion_sequencer_top_test;
   import hsms_pkg::*;

   localparam int unsigned HALF_PERIOD     = 5;
   localparam int unsigned RESET_CYCLES    = 11;
   localparam int unsigned RUN_LIMIT_NS    = 5_000_000;
   // Longest step is a divider pass; margin on top of that
   localparam int unsigned SETTLE_CYCLES   = 30;
   localparam int unsigned PHASES          = 12;
   localparam int unsigned ITEMS_PER_PHASE = 70;
   localparam int unsigned HOLD_CYCLES     = 200;
   localparam logic [2:0]  CSR_PAST_LIST   = 3'd5;

   // One response transaction as the block should present it
   typedef struct packed {
      mode_type    mode;
      logic [15:0] heading;
      logic [15:0] speed;
      logic [15:0] turns_left;
   } motion_result_type;

   // Directed plan: plain steps (predicted), steps with a typed-in result, register writes
   typedef enum logic [1:0] {ROW_STEP, ROW_KNOWN, ROW_CSR} plan_kind_type;

   typedef struct packed {
      plan_kind_type kind;
      logic [2:0]    index;    // register index, write rows only
      logic [15:0]   value;    // desired heading, or register data
      logic [2:0]    mode;     // typed-in result, ROW_KNOWN only
      logic [15:0]   heading;
      logic [15:0]   speed;
      logic [15:0]   turns;
   } plan_row_type;

   // Starts from reset values: threshold 1820, cruise 5120, step 256, turn 364, rate 364.
   localparam plan_row_type DIRECTED_PLAN [0:30] = '{
      // standstill with zero error: align and start accelerating, speed untouched
      '{ROW_KNOWN, '0, 16'h0000, MODE_ACCEL, 16'd0, 16'd0,   16'd0},
      // first ramp step
      '{ROW_KNOWN, '0, 16'h0000, MODE_ACCEL, 16'd0, 16'd256, 16'd0},
      // large error but still slow: keep ramping while turning by the limit
      '{ROW_STEP,  '0, 16'h7FFF, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h7FFF, '0, '0, '0, '0},
      // fast enough now: brake, then ramp down to zero and start a turn in place
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      // top bit of a 15-bit register is dropped
      '{ROW_CSR,   CSR_MAX_TURN_STEP, 16'hFFFF, '0, '0, '0, '0},
      // turn closes the error in one step, budget left behind
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      // cruise lowered below the current speed: ramp clips to cruise
      '{ROW_CSR,   CSR_CRUISE_SPEED, 16'd100, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      '{ROW_CSR,   CSR_CRUISE_SPEED, 16'hFFFF, '0, '0, '0, '0},
      '{ROW_CSR,   CSR_SPEED_STEP,   16'hFFFF, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h8000, '0, '0, '0, '0},
      // error of exactly half a turn
      '{ROW_STEP,  '0, 16'h0000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h0000, '0, '0, '0, '0},
      // zero turn rate acts as one; zero threshold; frozen heading
      '{ROW_CSR,   CSR_TURN_RATE_STEP, 16'h0000, '0, '0, '0, '0},
      '{ROW_CSR,   CSR_TURN_THRESHOLD, 16'h0000, '0, '0, '0, '0},
      '{ROW_CSR,   CSR_MAX_TURN_STEP,  16'h0000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h0000, '0, '0, '0, '0},
      '{ROW_CSR,   CSR_MAX_TURN_STEP,  16'h7FFF, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h0000, '0, '0, '0, '0},
      // zero cruise speed
      '{ROW_CSR,   CSR_CRUISE_SPEED, 16'h0000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h0001, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h4000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h4000, '0, '0, '0, '0},
      // write past the register list must be dropped
      '{ROW_CSR,   CSR_PAST_LIST, 16'h1234, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'h4000, '0, '0, '0, '0},
      '{ROW_STEP,  '0, 16'hC000, '0, '0, '0, '0}
   };

   // DUT connections; every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_desired_direction = 16'h0000;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_mode;
   logic [15:0] rsp_heading;
   logic [15:0] rsp_speed;
   logic [15:0] rsp_turn_steps_left;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_TURN_THRESHOLD;
   logic [15:0] csr_data = 16'h0000;

   // Predictor copy of the registers and of the machine state
   logic [14:0] threshold_set = TURN_THRESHOLD_RST;
   logic [15:0] cruise_set    = CRUISE_SPEED_RST;
   logic [15:0] step_set      = SPEED_STEP_RST;
   logic [14:0] max_turn_set  = MAX_TURN_STEP_RST;
   logic [14:0] rate_set      = TURN_RATE_STEP_RST;
   mode_type    mode_now      = MODE_STOPPED;
   logic [15:0] heading_now   = 16'h0000;
   logic [15:0] speed_now     = 16'h0000;
   logic [15:0] budget_now    = 16'h0000;

   motion_result_type expected_motion [$];
   int unsigned       mismatch_count = 0;

   // Idling controls shared by the sender and the receiver
   bit          no_idle = 1'b0;
   int unsigned rsp_hold_cycles = 0;

   heading_speed_motion_sequencer_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_desired_direction (req_desired_direction),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_mode              (rsp_mode),
      .rsp_heading           (rsp_heading),
      .rsp_speed             (rsp_speed),
      .rsp_turn_steps_left   (rsp_turn_steps_left),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------
   // Step predictor
   // ---------------------------------------------------------------

   // Wrapped signed difference want - have, -32768..32767
   function automatic int heading_error(input logic [15:0] want, input logic [15:0] have);
      logic [15:0] diff;
      diff = want - have;
      return int'($signed(diff));
   endfunction

   function automatic int error_size(input logic [15:0] want, input logic [15:0] have);
      int err;
      err = heading_error(want, have);
      return (err < 0) ? -err : err;
   endfunction

   // Rotate toward the target, clamped to max_turn_step
   function automatic void turn_toward(input logic [15:0] want);
      int err;
      int lim;
      err = heading_error(want, heading_now);
      lim = int'(max_turn_set);
      if (err > lim) err = lim;
      if (err < -lim) err = -lim;
      heading_now = heading_now + 16'(err);
   endfunction

   // Standing still: either start a turn in place (budget = ceil(error / rate))
   // or snap to the target and start ramping
   function automatic void leave_standstill(input logic [15:0] want);
      int mag;
      int divisor;
      mag = error_size(want, heading_now);
      if (mag > int'(threshold_set)) begin
         divisor = (rate_set == '0) ? 1 : int'(rate_set);
         budget_now = 16'((mag + divisor - 1) / divisor);
         mode_now = MODE_TURNING;
      end else begin
         heading_now = want;
         mode_now = MODE_ACCEL;
      end
   endfunction

   function automatic motion_result_type predict_motion_step(input logic [15:0] want);
      int mag;
      int big;
      int raised;
      motion_result_type res;
      mag = error_size(want, heading_now);
      big = 2 * int'(threshold_set);
      case (mode_now)
         MODE_ACCEL: begin
            if (mag > big && 10 * int'(speed_now) > int'(cruise_set)) begin
               mode_now = MODE_DECEL;
            end else begin
               raised = int'(speed_now) + int'(step_set);
               turn_toward(want);
               speed_now = (raised < int'(cruise_set)) ? 16'(raised) : cruise_set;
               if (int'(speed_now) + int'(SPEED_EPS) >= int'(cruise_set)) mode_now = MODE_CRUISE;
            end
         end
         MODE_DECEL: begin
            speed_now = (speed_now > step_set) ? speed_now - step_set : 16'h0000;
            if (speed_now < SPEED_EPS) begin
               speed_now = 16'h0000;
               leave_standstill(want);
            end
         end
         MODE_TURNING: begin
            turn_toward(want);
            mag = error_size(want, heading_now);
            if (budget_now == 16'h0000) begin
               mode_now = MODE_ACCEL;
            end else begin
               budget_now = budget_now - 16'd1;
               if (budget_now == 16'h0000 || mag < int'(ANGLE_EPS)) mode_now = MODE_ACCEL;
            end
         end
         MODE_CRUISE: begin
            if (mag > big) begin
               mode_now = MODE_DECEL;
            end else begin
               turn_toward(want);
               speed_now = cruise_set;
            end
         end
         default: begin
            leave_standstill(want);
         end
      endcase
      res.mode       = mode_now;
      res.heading    = heading_now;
      res.speed      = speed_now;
      res.turns_left = budget_now;
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------

   // Mostly back to back or short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_setting(input logic [15:0] low_end,
                                                input logic [15:0] high_end,
                                                input int unsigned typ_lo,
                                                input int unsigned typ_hi);
      case ($urandom_range(0, 6))
         0: return low_end;
         1: return high_end;
         default: return 16'($urandom_range(typ_lo, typ_hi));
      endcase
   endfunction

   // Offer one request transaction after `gap` idle cycles; returns at the
   // accepting edge. Valid is only lowered when a gap follows, so a
   // back-to-back transaction never sees valid dropped and raised in one step.
   task automatic send_heading(input logic [15:0] dir, input int unsigned gap);
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_desired_direction <= dir;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Register write; the caller drops csr_valid after the last one
   task automatic write_register(input logic [2:0] index, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         CSR_TURN_THRESHOLD: threshold_set = data[14:0];
         CSR_CRUISE_SPEED:   cruise_set    = data;
         CSR_SPEED_STEP:     step_set      = data;
         CSR_MAX_TURN_STEP:  max_turn_set  = data[14:0];
         CSR_TURN_RATE_STEP: rate_set      = data[14:0];
         default: ;
      endcase
   endtask

   // Stop offering requests and let every outstanding step come back
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Receiver: random ready gaps, plus a long hold-off on request
   // ---------------------------------------------------------------
   initial begin : rsp_sink
      int unsigned ready_gap;
      ready_gap = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (ready_gap != 0) begin
            rsp_ready <= 1'b0;
            ready_gap--;
         end else begin
            rsp_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) ready_gap = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------
   // Checker: each response transaction against the oldest expectation
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      motion_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_motion.size() == 0) begin
            $error("response transaction with no step outstanding");
            mismatch_count++;
         end else begin
            want = expected_motion.pop_front();
            if (rsp_mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_mode);
               mismatch_count++;
            end
            if (rsp_heading !== want.heading) begin
               $error("heading: expected %h, got %h", want.heading, rsp_heading);
               mismatch_count++;
            end
            if (rsp_speed !== want.speed) begin
               $error("speed: expected %0d, got %0d", want.speed, rsp_speed);
               mismatch_count++;
            end
            if (rsp_turn_steps_left !== want.turns_left) begin
               $error("turn_steps_left: expected %0d, got %0d",
                      want.turns_left, rsp_turn_steps_left);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin : stimulus
      plan_row_type      row;
      motion_result_type predicted;
      motion_result_type typed;
      logic [15:0]       dir;
      logic [15:0]       aim;
      int unsigned       roll;
      int unsigned       gap;
      bit                burst;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed plan; typed-in rows still advance the predictor state
      for (int r = 0; r < $size(DIRECTED_PLAN); r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_CSR) begin
            settle_block();
            write_register(row.index, row.value);
            @(negedge clock);
            csr_valid <= 1'b0;
         end else begin
            send_heading(row.value, pick_gap());
            predicted = predict_motion_step(row.value);
            if (row.kind == ROW_KNOWN) begin
               typed = '{mode_type'(row.mode), row.heading, row.speed, row.turns};
               expected_motion.push_back(typed);
            end else begin
               expected_motion.push_back(predicted);
            end
         end
      end

      // Random phases: each one reprograms every register while the block is idle.
      // Phase 0 goes back to reset values; later ones mix extremes with typical values.
      aim = 16'($urandom());
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         settle_block();
         no_idle = 1'b0;
         if (phase == 0) begin
            write_register(CSR_TURN_THRESHOLD, 16'(TURN_THRESHOLD_RST));
            write_register(CSR_CRUISE_SPEED,   CRUISE_SPEED_RST);
            write_register(CSR_SPEED_STEP,     SPEED_STEP_RST);
            write_register(CSR_MAX_TURN_STEP,  16'(MAX_TURN_STEP_RST));
            write_register(CSR_TURN_RATE_STEP, 16'(TURN_RATE_STEP_RST));
         end else begin
            write_register(CSR_TURN_THRESHOLD, pick_setting(16'h0000, 16'hFFFF, 200, 6000));
            write_register(CSR_CRUISE_SPEED,   pick_setting(16'h0000, 16'hFFFF, 256, 8192));
            write_register(CSR_SPEED_STEP,     pick_setting(16'h0000, 16'hFFFF, 16, 2048));
            write_register(CSR_MAX_TURN_STEP,  pick_setting(16'h0000, 16'hFFFF, 32, 4000));
            write_register(CSR_TURN_RATE_STEP, pick_setting(16'h0000, 16'hFFFF, 32, 4000));
         end
         @(negedge clock);
         csr_valid <= 1'b0;

         // Some phases run with no random idle gaps on either side
         no_idle = (phase % 5 == 2);

         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Pressure: the receiver holds off for a long stretch while requests keep
            // coming back to back, so the held result backs up and req_ready drops.
            burst = (phase % 4 == 3) && (n >= 20) && (n < 40);
            if ((phase % 4 == 3) && n == 20) rsp_hold_cycles = HOLD_CYCLES;

            // Sender pause mid-phase until every outstanding step has come back
            if ((phase % 2 == 0) && n == 50) settle_block();

            // Mostly a steady target with jitter so the machine gets to cruise;
            // the rest are new targets, wrap-edge headings and pure noise
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               dir = aim + 16'($urandom_range(0, 300)) - 16'd150;
            end else if (roll < 86) begin
               aim = 16'($urandom());
               dir = aim;
            end else if (roll < 93) begin
               case ($urandom_range(0, 3))
                  0: dir = 16'h7FFF;
                  1: dir = 16'h8000;
                  2: dir = aim ^ 16'h8000;
                  default: dir = 16'hFFFF;
               endcase
            end else begin
               dir = 16'($urandom());
            end

            gap = burst ? 0 : pick_gap();
            send_heading(dir, gap);
            expected_motion.push_back(predict_motion_step(dir));
         end
      end

      // Drain, give the block its worst-case latency, then report
      settle_block();
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop if the handshakes ever hang
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
